### rtl/hfc_pkg.sv
// ----------------------------------------------------------------------------
// hfc_pkg: shared types and constants for the half float converter
// Action codes and the fixed bit patterns of the binary32 and binary16
// formats.
// ----------------------------------------------------------------------------
package hfc_pkg;

    typedef enum logic [1:0] {
        ACT_SINGLE_TO_HALF = 2'd0,
        ACT_HALF_TO_SINGLE = 2'd1,
        ACT_SINGLE_TO_BF16 = 2'd2,
        ACT_BF16_TO_SINGLE = 2'd3
    } action_t;

    // Half format fields
    localparam logic [15:0] HALF_SIGN_MASK = 16'h8000;
    localparam logic [15:0] HALF_INF       = 16'h7c00;
    localparam logic [15:0] HALF_QNAN_BIT  = 16'h0200;

    // Single format fields
    localparam logic [31:0] SINGLE_INF     = 32'h7f80_0000;
    localparam logic [7:0]  SINGLE_EXP_MAX = 8'hff;

    // Exponent bias difference (127 - 15) and its derived limits
    localparam logic [7:0]  EXP_REBIAS     = 8'd112;
    localparam logic [7:0]  EXP_HALF_OVF   = 8'd143;  // half exponent reaches 31
    localparam logic [7:0]  EXP_HALF_SUB   = 8'd102;  // smallest exponent kept as subnormal
    localparam logic [7:0]  EXP_SUB_SHIFT  = 8'd126;  // shift = 126 - exponent
    localparam logic [7:0]  EXP_SUB_NORM   = 8'd103;  // single exponent of half subnormal bit 0

endpackage

### rtl/half_float_converter_unit.sv
// ----------------------------------------------------------------------------
// half_float_converter_unit: binary32 / binary16 / bfloat16 converter
// Converts one bit pattern per transaction in the direction chosen by action.
// ----------------------------------------------------------------------------
// Each accepted transaction yields exactly one result, in order. The unit is
// a two-register pipeline: the operand is captured in an input register, the
// whole conversion is one pass of combinational logic, and the result is held
// in an output register. Throughput is one transaction per clock cycle while
// the output is not stalled; each operand passes the input register, then the
// output register. A stall on the output holds both stages; the input is
// stalled only when both stages are full and the output is stalled.
module half_float_converter_unit
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           action,
    input  logic [31:0]          operand_bits,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [31:0]          result_bits
);
    import hfc_pkg::*;

    logic        s1_valid_reg;
    logic [1:0]  s1_action_reg;
    logic [31:0] s1_operand_reg;
    logic        out_valid_reg;
    logic [31:0] result_reg;
    logic [31:0] result_next;

    logic        out_hold;
    logic        s1_hold;
    logic        s1_load;
    logic        out_load;

    // Pipeline enables
    assign out_hold = out_valid_reg & out_stall;
    assign s1_hold  = s1_valid_reg & out_hold;
    assign s1_load  = ~s1_hold;
    assign out_load = ~out_hold;
    assign in_stall = s1_hold;

    // Single to half fields
    logic        sh_sign;
    logic [7:0]  sh_exp;
    logic [22:0] sh_mant;
    logic [7:0]  sh_exp_adj;
    logic [4:0]  sh_shift;
    logic [23:0] sh_sig;
    logic [23:0] sh_sig_shr;
    logic [23:0] sh_sig_rnd;
    logic [10:0] sh_sub;
    logic [15:0] sh_result;

    // Half to single fields
    logic        hs_sign;
    logic [4:0]  hs_exp;
    logic [9:0]  hs_mant;
    logic [3:0]  hs_lead;
    logic [3:0]  hs_norm_shift;
    logic [32:0] hs_frac_wide;
    logic [7:0]  hs_sub_exp;
    logic [31:0] hs_result;

    // Convert single to half
    always_comb
    begin
        sh_sign    = s1_operand_reg[31];
        sh_exp     = s1_operand_reg[30:23];
        sh_mant    = s1_operand_reg[22:0];
        sh_exp_adj = sh_exp - EXP_REBIAS;
        sh_shift   = 5'(EXP_SUB_SHIFT - sh_exp);
        sh_sig     = {1'b1, sh_mant};
        sh_sig_shr = sh_sig >> sh_shift;
        sh_sig_rnd = sh_sig >> (sh_shift - 5'd1);
        sh_sub     = sh_sig_shr[10:0] + {10'd0, sh_sig_rnd[0]};
        priority if (sh_exp == SINGLE_EXP_MAX)
        begin
            sh_result = HALF_INF | ((sh_mant != 23'd0) ? HALF_QNAN_BIT : 16'd0);
        end
        else if (sh_exp >= EXP_HALF_OVF)
        begin
            sh_result = HALF_INF;
        end
        else if (sh_exp > EXP_REBIAS)
        begin
            sh_result = {1'b0, sh_exp_adj[4:0], sh_mant[22:13]};
        end
        else if (sh_exp >= EXP_HALF_SUB)
        begin
            sh_result = {5'd0, sh_sub};
        end
        else
        begin
            sh_result = 16'd0;
        end
        if (sh_sign)
        begin
            sh_result = sh_result | HALF_SIGN_MASK;
        end
    end

    // Find the leading one of a half subnormal mantissa
    always_comb
    begin
        hs_lead = 4'd0;
        for (int i = 0; i < 10; i++)
        begin
            if (hs_mant[i])
            begin
                hs_lead = 4'(i);
            end
        end
    end

    // Convert half to single
    always_comb
    begin
        hs_sign       = s1_operand_reg[15];
        hs_exp        = s1_operand_reg[14:10];
        hs_mant       = s1_operand_reg[9:0];
        hs_norm_shift = 4'd10 - hs_lead;
        hs_frac_wide  = {10'd0, hs_mant, 13'd0} << hs_norm_shift;
        hs_sub_exp    = EXP_SUB_NORM + {4'd0, hs_lead};
        priority if (hs_exp == 5'd0 && hs_mant == 10'd0)
        begin
            hs_result = 32'd0;
        end
        else if (hs_exp == 5'd0)
        begin
            hs_result = {1'b0, hs_sub_exp, hs_frac_wide[22:0]};
        end
        else if (hs_exp == 5'h1f)
        begin
            hs_result = SINGLE_INF | {9'd0, hs_mant, 13'd0};
        end
        else
        begin
            hs_result = {1'b0, {3'd0, hs_exp} + EXP_REBIAS, hs_mant, 13'd0};
        end
        hs_result[31] = hs_sign;
    end

    // Select the conversion by action
    always_comb
    begin
        unique case (action_t'(s1_action_reg))
            ACT_SINGLE_TO_HALF: result_next = {16'd0, sh_result};
            ACT_HALF_TO_SINGLE: result_next = hs_result;
            ACT_SINGLE_TO_BF16: result_next = {16'd0, s1_operand_reg[31:16]};
            ACT_BF16_TO_SINGLE: result_next = {s1_operand_reg[15:0], 16'd0};
            default:            result_next = 32'd0;
        endcase
    end

    // Advance the input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_load)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load && in_valid)
        begin
            s1_action_reg  <= action;
            s1_operand_reg <= operand_bits;
        end
    end

    // Advance the output stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load && s1_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_bits = result_reg;

endmodule

### rtl/hfc_checker.sv
// ----------------------------------------------------------------------------
// hfc_checker: port-level checks for the half float converter
// Watches the handshakes on both channels and the pipeline timing.
// ----------------------------------------------------------------------------
module hfc_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [31:0] result_bits
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(result_bits)))
        else $error("stalled result changed or dropped");

    // Stall the input only under output back-pressure
    a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without output back-pressure");

    // Produce a fresh result only after a transaction has been accepted
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
        else $error("result appeared without an accepted transaction");

    // Make a result valid after a transaction is accepted
    // while the output is not stalled
    a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && !out_stall) |=> ##1 out_valid)
        else $error("accepted transaction did not reach the output");

endmodule

bind half_float_converter_unit hfc_checker u_hfc_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result_bits (result_bits)
);

### bench/half_float_converter_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// half_float_converter_unit_test: self-checking bench for the converter
// A table of corner-case transactions runs first, then random transactions
// in all four directions. Each result is compared in order with a known table
// value or a behavioral conversion model, with random gaps on input and output.
// ----------------------------------------------------------------------------
module half_float_converter_unit_test;

    import hfc_pkg::*;

    localparam int NUM_PROBES  = 25;
    localparam int NUM_RANDOM  = 1250;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        action_t     act;
        logic [31:0] operand;
        logic        known;
        logic [31:0] want;
    } probe_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    action_t     action;
    logic [31:0] operand_bits;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] result_bits;

    logic [31:0] pending_results[$];
    int          mismatch_count = 0;
    int          cycle_count    = 0;
    int          stall_left     = 0;
    bit          quiet          = 1'b0;

    // Corner cases; a known result is given only where it is obvious
    probe_t corner_probes [NUM_PROBES] = '{
        '{ACT_SINGLE_TO_HALF, 32'h0000_0000, 1'b1, 32'h0000_0000},  // +0
        '{ACT_SINGLE_TO_HALF, 32'h8000_0000, 1'b1, 32'h0000_8000},  // -0
        '{ACT_SINGLE_TO_HALF, 32'h3f80_0000, 1'b1, 32'h0000_3c00},  // 1.0
        '{ACT_SINGLE_TO_HALF, 32'h7f80_0000, 1'b1, 32'h0000_7c00},  // +inf
        '{ACT_SINGLE_TO_HALF, 32'hff80_0000, 1'b1, 32'h0000_fc00},  // -inf
        '{ACT_SINGLE_TO_HALF, 32'h7fc0_0001, 1'b1, 32'h0000_7e00},  // quiet NaN
        '{ACT_SINGLE_TO_HALF, 32'hff80_0001, 1'b1, 32'h0000_fe00},  // signalling NaN
        '{ACT_SINGLE_TO_HALF, 32'h4780_0000, 1'b1, 32'h0000_7c00},  // overflow
        '{ACT_SINGLE_TO_HALF, 32'h477f_e000, 1'b0, 32'h0},          // largest half
        '{ACT_SINGLE_TO_HALF, 32'h807f_ffff, 1'b1, 32'h0000_8000},  // single subnormal
        '{ACT_SINGLE_TO_HALF, 32'h387f_ffff, 1'b0, 32'h0},          // rounding carry
        '{ACT_SINGLE_TO_HALF, 32'h3300_0000, 1'b0, 32'h0},          // smallest subnormal
        '{ACT_SINGLE_TO_HALF, 32'hb280_0000, 1'b1, 32'h0000_8000},  // underflow
        '{ACT_HALF_TO_SINGLE, 32'hffff_3c00, 1'b1, 32'h3f80_0000},  // upper bits ignored
        '{ACT_HALF_TO_SINGLE, 32'h0000_0001, 1'b0, 32'h0},          // smallest subnormal
        '{ACT_HALF_TO_SINGLE, 32'h0000_83ff, 1'b0, 32'h0},          // largest subnormal
        '{ACT_HALF_TO_SINGLE, 32'h0000_7c00, 1'b1, 32'h7f80_0000},  // +inf
        '{ACT_HALF_TO_SINGLE, 32'h0000_fc00, 1'b1, 32'hff80_0000},  // -inf
        '{ACT_HALF_TO_SINGLE, 32'h0000_7c01, 1'b1, 32'h7f80_2000},  // signalling NaN
        '{ACT_HALF_TO_SINGLE, 32'h0000_8000, 1'b1, 32'h8000_0000},  // -0
        '{ACT_SINGLE_TO_BF16, 32'hffff_ffff, 1'b1, 32'h0000_ffff},
        '{ACT_SINGLE_TO_BF16, 32'h7f80_0001, 1'b1, 32'h0000_7f80},  // NaN truncates to inf
        '{ACT_SINGLE_TO_BF16, 32'h1234_5678, 1'b1, 32'h0000_1234},
        '{ACT_BF16_TO_SINGLE, 32'hdead_7f81, 1'b1, 32'h7f81_0000},
        '{ACT_BF16_TO_SINGLE, 32'h0000_ffff, 1'b1, 32'hffff_0000}
    };

    half_float_converter_unit dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .operand_bits (operand_bits),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_bits  (result_bits)
    );

    // Compute the converted pattern for one transaction
    function automatic logic [31:0] convert_pattern(action_t act, logic [31:0] src);
        logic        sgn;
        logic [7:0]  exp8;
        logic [22:0] frac;
        int          half_exp;
        int          shift;
        int          sexp;
        logic [23:0] full_frac;
        logic [24:0] rounded;
        logic [15:0] half_val;
        logic [4:0]  hexp;
        logic [10:0] norm_frac;
        logic [31:0] conv;
        begin
            conv = 32'h0;
            case (act)
                ACT_SINGLE_TO_HALF:
                begin
                    sgn      = src[31];
                    exp8     = src[30:23];
                    frac     = src[22:0];
                    half_exp = int'(exp8) - int'(EXP_REBIAS);
                    if (exp8 == SINGLE_EXP_MAX)
                        half_val = {sgn, 5'h1f, (frac != 23'h0) ? 10'h200 : 10'h000};
                    else if (half_exp >= 31)
                        half_val = {sgn, 5'h1f, 10'h000};
                    else if (half_exp < -10)
                        half_val = {sgn, 15'h0};
                    else if (half_exp <= 0)
                    begin
                        // shift in the hidden bit, round half up
                        full_frac = {1'b1, frac};
                        shift     = 14 - half_exp;
                        rounded   = (full_frac >> shift) + ((full_frac >> (shift - 1)) & 24'd1);
                        half_val  = {sgn, rounded[14:0]};
                    end
                    else
                        half_val = {sgn, 5'(half_exp), frac[22:13]};
                    conv = {16'h0, half_val};
                end
                ACT_HALF_TO_SINGLE:
                begin
                    sgn  = src[15];
                    hexp = src[14:10];
                    if (hexp == 5'd0)
                    begin
                        if (src[9:0] == 10'h0)
                            conv = {sgn, 31'h0};
                        else
                        begin
                            // normalize the subnormal
                            norm_frac = {1'b0, src[9:0]};
                            sexp      = 113;
                            while (!norm_frac[10])
                            begin
                                norm_frac = norm_frac << 1;
                                sexp      = sexp - 1;
                            end
                            conv = {sgn, 8'(sexp), norm_frac[9:0], 13'h0};
                        end
                    end
                    else if (hexp == 5'h1f)
                        conv = {sgn, 8'hff, src[9:0], 13'h0};
                    else
                        conv = {sgn, 8'(int'(hexp) + int'(EXP_REBIAS)), src[9:0], 13'h0};
                end
                ACT_SINGLE_TO_BF16:
                    conv = {16'h0, src[31:16]};
                default:
                    conv = {src[15:0], 16'h0};
            endcase
            return conv;
        end
    endfunction

    // Mostly short bursts, a few long ones
    function automatic int burst_length();
        begin
            if ($urandom_range(0, 99) < 85)
                return $urandom_range(1, 3);
            return $urandom_range(8, 30);
        end
    endfunction

    function automatic int input_gap();
        begin
            if (quiet || $urandom_range(0, 99) < 65)
                return 0;
            return burst_length();
        end
    endfunction

    // Bias operands toward exponents near the format boundaries
    function automatic logic [31:0] make_operand(action_t act);
        logic [31:0] bits;
        begin
            bits = $urandom;
            if (act == ACT_SINGLE_TO_HALF)
            begin
                case ($urandom_range(0, 4))
                    0: ;
                    1: bits[30:23] = 8'($urandom_range(98, 146));
                    2: bits[30:23] = $urandom_range(0, 1) ? 8'hff : 8'h00;
                    3:
                    begin
                        bits[30:23] = 8'($urandom_range(101, 113));
                        bits[22:0]  = $urandom_range(0, 1) ? 23'h7fffff : 23'h400000;
                        bits[12:0]  = $urandom_range(0, 1) ? bits[12:0] : 13'h0;
                    end
                    default: bits[22:0] = $urandom_range(0, 1) ? 23'h0 : 23'h1;
                endcase
            end
            else if (act == ACT_HALF_TO_SINGLE)
            begin
                case ($urandom_range(0, 3))
                    0: bits[14:10] = 5'h00;
                    1: bits[14:10] = 5'h1f;
                    2: bits[9:0]   = 10'($urandom_range(0, 3));
                    default: ;
                endcase
            end
            return bits;
        end
    endfunction

    // Present one transaction and hold it until accepted
    task automatic drive_item(action_t act, logic [31:0] src, logic known, logic [31:0] want);
        int gap;
        begin
            gap = input_gap();
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_valid     <= 1'b1;
            action       <= act;
            operand_bits <= src;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            pending_results.push_back(known ? want : convert_pattern(act, src));
        end
    endtask

    // Clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Output back-pressure
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else if (!quiet && $urandom_range(0, 99) < 25)
        begin
            stall_left <= burst_length() - 1;
            out_stall  <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // Compare each result with the oldest pending one
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected result, expected none actual %h", $time, result_bits);
            end
            else if (result_bits !== pending_results[0])
            begin
                mismatch_count++;
                $display("%0t: result_bits mismatch, expected %h actual %h",
                         $time, pending_results[0], result_bits);
                void'(pending_results.pop_front());
            end
            else
                void'(pending_results.pop_front());
        end
    end

    // Timeout
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("half_float_converter_unit regression: fail");
            $finish;
        end
    end

    // Stimulus
    initial
    begin
        action_t act;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        action       = ACT_SINGLE_TO_HALF;
        operand_bits = 32'h0;
        out_stall    = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // walk the corner-case table
        for (int i = 0; i < NUM_PROBES; i++)
            drive_item(corner_probes[i].act, corner_probes[i].operand,
                       corner_probes[i].known, corner_probes[i].want);

        // random transactions, with quiet stretches now and then
        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            if (i % 150 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            act = action_t'($urandom_range(0, 3));
            drive_item(act, make_operand(act), 1'b0, 32'h0);
        end
        in_valid <= 1'b0;
        quiet = 1'b0;

        // drain
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatch_count == 0)
            $display("half_float_converter_unit regression: pass");
        else
            $display("half_float_converter_unit regression: fail");
        $finish;
    end

endmodule

### filelist.f
rtl/hfc_pkg.sv
rtl/half_float_converter_unit.sv
rtl/hfc_checker.sv
bench/half_float_converter_unit_test.sv
